// ===== rtl/core/mtfp_pkg.sv =====
// mtfp_pkg: shared types and constants for the modbus/tcp frame parser core
// no dependencies; used by modbus_tcp_frame_parser_core

package mtfp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_TRUNC    = 2'd1,
    STATUS_ZERO_LEN = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [0:0] CFG_HIGH_THRESHOLD = 1'd0;
  localparam logic [0:0] CFG_WRITE_CODE     = 1'd1;

  // configuration reset values
  localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd3000;
  localparam logic [7:0]  WRITE_CODE_RESET     = 8'h06;

  // byte position codes: 0-5 header words, unit byte, inside pdu
  localparam logic [2:0] POS_UNIT = 3'd6;
  localparam logic [2:0] POS_PDU  = 3'd7;

  // pdu capture index saturates once value word is complete
  localparam logic [2:0] PDU_IDX_FUNC  = 3'd0;
  localparam logic [2:0] PDU_IDX_ADDRH = 3'd1;
  localparam logic [2:0] PDU_IDX_ADDRL = 3'd2;
  localparam logic [2:0] PDU_IDX_VALH  = 3'd3;
  localparam logic [2:0] PDU_IDX_VALL  = 3'd4;
  localparam logic [2:0] PDU_IDX_DONE  = 3'd5;

  typedef struct packed {
    logic [15:0] txn_id;
    logic [15:0] proto_id;
    logic [15:0] length_field;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic        is_write_single;
    logic        value_high_flag;
    logic [15:0] frame_index;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/core/modbus_tcp_frame_parser_core.sv =====
// modbus_tcp_frame_parser_core: byte-wide modbus/tcp mbap header and pdu parser
// depends on mtfp_pkg for result type, status codes and register indexes

// usage
//   s_* channel: one stream byte per word, s_tlast marks the last byte of a log.
//   m_* channel: one word per completed frame, or one error word for a zero
//     length field or a pdu cut off by end of stream. m_tuser carries status.
//   cfg_*: write-only register port, written while the parser is idle.
// results: the byte that completes a frame loads its result into the output
//   register, or into the skid entry while the output word is held.
// throughput: one byte per clock while s_tready is high; each byte only updates
//   the position counters and field registers; the result is registered once.
// stalls: an output register plus one skid entry sit behind the parser;
//   s_tready drops only while the skid entry is occupied, so a stalled
//   receiver holds at most two results before input is back-pressured.
// reset: rst (synchronous) returns the parser to the first header byte,
//   clears the frame counter and halt state, drops both output entries and
//   restores threshold 3000 and write function code 6.
// after a zero length error result all bytes are dropped up to and including
//   the next byte with s_tlast set.

module modbus_tcp_frame_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // end_of_stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // txn_id, proto_id, length_field, unit_id, func_code,
  // reg_addr, reg_value, is_write_single, value_high_flag,
  // frame_index, zero fill
  output logic [119:0] m_tdata,
  output logic [1:0]   m_tuser    // status
);

  // configuration
  logic [15:0] high_value_threshold;
  logic [7:0]  write_function_code;

  // parser state
  logic [2:0]  byte_position, byte_position_next;
  logic [15:0] pdu_remaining, pdu_remaining_next;
  logic [2:0]  pdu_index, pdu_index_next;
  logic [15:0] header_words [3];
  logic [15:0] header_words_next [3];
  logic [7:0]  unit_byte, unit_byte_next;
  logic [7:0]  function_byte, function_byte_next;
  logic [15:0] address_word, address_word_next;
  logic [15:0] value_word, value_word_next;
  logic        halted, halted_next;
  logic [15:0] good_frame_count, good_frame_count_next;

  // result path
  logic               accept;
  logic               push;
  mtfp_pkg::status_t  push_status;
  mtfp_pkg::result_t  result;
  logic               wr_match;
  logic [1:0]         word_sel;

  // output register and skid entry
  logic              out_valid;
  mtfp_pkg::result_t out_word;
  logic              skid_valid;
  mtfp_pkg::result_t skid_word;
  logic              pop;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign word_sel = byte_position[2:1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_value_threshold <= mtfp_pkg::HIGH_THRESHOLD_RESET;
      write_function_code  <= mtfp_pkg::WRITE_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtfp_pkg::CFG_HIGH_THRESHOLD: high_value_threshold <= cfg_data;
        mtfp_pkg::CFG_WRITE_CODE:     write_function_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // per-byte parse step
  always_comb begin
    byte_position_next    = byte_position;
    pdu_remaining_next    = pdu_remaining;
    pdu_index_next        = pdu_index;
    header_words_next     = header_words;
    unit_byte_next        = unit_byte;
    function_byte_next    = function_byte;
    address_word_next     = address_word;
    value_word_next       = value_word;
    halted_next           = halted;
    good_frame_count_next = good_frame_count;
    push                  = 1'b0;
    push_status           = mtfp_pkg::STATUS_GOOD;

    if (!halted) begin
      if (byte_position < mtfp_pkg::POS_UNIT) begin
        // header words arrive high byte first
        if (!byte_position[0]) begin
          header_words_next[word_sel] = {s_tdata, 8'h00};
        end else begin
          header_words_next[word_sel] = header_words[word_sel] | {8'h00, s_tdata};
        end
        byte_position_next = byte_position + 3'd1;
      end else if (byte_position == mtfp_pkg::POS_UNIT) begin
        unit_byte_next     = s_tdata;
        function_byte_next = 8'h00;
        address_word_next  = 16'h0000;
        value_word_next    = 16'h0000;
        pdu_index_next     = mtfp_pkg::PDU_IDX_FUNC;
        if (header_words[2] == 16'd0) begin
          push        = 1'b1;
          push_status = mtfp_pkg::STATUS_ZERO_LEN;
          halted_next = 1'b1;
        end else if (header_words[2] == 16'd1) begin
          // empty pdu, frame ends on the unit byte
          push                  = 1'b1;
          good_frame_count_next = good_frame_count + 16'd1;
          byte_position_next    = 3'd0;
        end else begin
          pdu_remaining_next = header_words[2] - 16'd1;
          byte_position_next = mtfp_pkg::POS_PDU;
        end
      end else begin
        unique case (pdu_index)
          mtfp_pkg::PDU_IDX_FUNC:  function_byte_next = s_tdata;
          mtfp_pkg::PDU_IDX_ADDRH: address_word_next  = {s_tdata, 8'h00};
          mtfp_pkg::PDU_IDX_ADDRL: address_word_next  = address_word | {8'h00, s_tdata};
          mtfp_pkg::PDU_IDX_VALH:  value_word_next    = {s_tdata, 8'h00};
          mtfp_pkg::PDU_IDX_VALL:  value_word_next    = value_word | {8'h00, s_tdata};
          default: ;
        endcase
        if (pdu_index < mtfp_pkg::PDU_IDX_DONE) begin
          pdu_index_next = pdu_index + 3'd1;
        end
        pdu_remaining_next = pdu_remaining - 16'd1;
        if (pdu_remaining_next == 16'd0) begin
          push                  = 1'b1;
          good_frame_count_next = good_frame_count + 16'd1;
          byte_position_next    = 3'd0;
        end
      end

      // stream ended inside a pdu with no frame completed
      if (s_tlast && !push && byte_position_next == mtfp_pkg::POS_PDU) begin
        push        = 1'b1;
        push_status = mtfp_pkg::STATUS_TRUNC;
      end
    end

    // result word from the updated fields
    wr_match = (function_byte_next == write_function_code)
               && (push_status == mtfp_pkg::STATUS_GOOD);
    result.txn_id           = header_words_next[0];
    result.proto_id         = header_words_next[1];
    result.length_field     = header_words_next[2];
    result.unit_id          = unit_byte_next;
    result.func_code        = (push_status == mtfp_pkg::STATUS_GOOD)
                              ? function_byte_next : 8'h00;
    result.reg_addr         = wr_match ? address_word_next : 16'h0000;
    result.reg_value        = wr_match ? value_word_next : 16'h0000;
    result.is_write_single  = wr_match;
    result.value_high_flag  = wr_match && (value_word_next > high_value_threshold);
    result.frame_index      = good_frame_count_next;
    result.status           = push_status;

    // end of stream restarts parsing, halted or not
    if (s_tlast) begin
      byte_position_next    = 3'd0;
      pdu_remaining_next    = 16'd0;
      pdu_index_next        = mtfp_pkg::PDU_IDX_FUNC;
      halted_next           = 1'b0;
      good_frame_count_next = 16'd0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 3'd0;
      pdu_remaining    <= 16'd0;
      pdu_index        <= mtfp_pkg::PDU_IDX_FUNC;
      header_words     <= '{default: 16'h0000};
      unit_byte        <= 8'h00;
      function_byte    <= 8'h00;
      address_word     <= 16'h0000;
      value_word       <= 16'h0000;
      halted           <= 1'b0;
      good_frame_count <= 16'd0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      pdu_remaining    <= pdu_remaining_next;
      pdu_index        <= pdu_index_next;
      header_words     <= header_words_next;
      unit_byte        <= unit_byte_next;
      function_byte    <= function_byte_next;
      address_word     <= address_word_next;
      value_word       <= value_word_next;
      halted           <= halted_next;
      good_frame_count <= good_frame_count_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      // skid is empty whenever a byte is taken, so at most one source here
      out_valid  <= skid_valid || (accept && push);
      skid_valid <= 1'b0;
    end else if (accept && push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_word <= skid_valid ? skid_word : result;
    end else if (accept && push) begin
      skid_word <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {
    6'b0,
    out_word.frame_index,
    out_word.value_high_flag,
    out_word.is_write_single,
    out_word.reg_value,
    out_word.reg_addr,
    out_word.func_code,
    out_word.unit_id,
    out_word.length_field,
    out_word.proto_id,
    out_word.txn_id
  };
  assign m_tuser  = out_word.status;

`ifndef SYNTHESIS
  // skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // pdu byte count is live exactly while inside a pdu
  a_pdu_count: assert property (@(posedge clk) disable iff (rst)
    (byte_position == mtfp_pkg::POS_PDU) == (pdu_remaining != 16'd0))
    else $error("pdu_remaining out of step with byte position");

  // halt only follows a zero length seen on the unit byte
  a_halt_pos: assert property (@(posedge clk) disable iff (rst)
    halted |-> byte_position == mtfp_pkg::POS_UNIT)
    else $error("halted outside unit byte position");

  // a halted parser never produces a result
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && halted) |=> !skid_valid || $past(skid_valid))
    else $error("result produced while halted");
`endif

endmodule
